// ===== rtl/json_string_escaper_top_defines.svh =====
// ---------------------------------------------------------------------------
// json string escaper assertion macros
// concurrent assertion wrappers clocked on clk, quiet during reset
// ---------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

// implication in the same cycle
`define JSE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jse_pkg.sv =====
// ---------------------------------------------------------------------------
// jse_pkg
// character constants and helpers for the json string escaper
// ---------------------------------------------------------------------------
package jse_pkg;

	localparam int unsigned MAX_RUN = 8;
	localparam int unsigned RUN_W   = $clog2(MAX_RUN);

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_U       = 8'h75;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [3:0] NIBBLE_MASK = 4'hF;

	localparam logic [7:0] C_BS  = 8'h08;
	localparam logic [7:0] C_TAB = 8'h09;
	localparam logic [7:0] C_LF  = 8'h0A;
	localparam logic [7:0] C_FF  = 8'h0C;
	localparam logic [7:0] C_CR  = 8'h0D;

	typedef logic [7:0] byte_t;

	function automatic byte_t hex_char(input logic [3:0] nib);
		byte_t r;
		case (nib & NIBBLE_MASK)
			4'h0: r = 8'h30;
			4'h1: r = 8'h31;
			4'h2: r = 8'h32;
			4'h3: r = 8'h33;
			4'h4: r = 8'h34;
			4'h5: r = 8'h35;
			4'h6: r = 8'h36;
			4'h7: r = 8'h37;
			4'h8: r = 8'h38;
			4'h9: r = 8'h39;
			4'hA: r = 8'h61;
			4'hB: r = 8'h62;
			4'hC: r = 8'h63;
			4'hD: r = 8'h64;
			4'hE: r = 8'h65;
			default: r = 8'h66;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/json_string_escaper_top.sv =====
// ---------------------------------------------------------------------------
// json_string_escaper_top
// escapes string bytes into json string text; with out_stall low, one output byte per cycle
// ---------------------------------------------------------------------------
// channel  direction  handshake            payload
// input    in         in_valid / in_stall  data_byte first_byte last_byte empty_string
// output   out        out_valid / out_stall out_byte run_end
//
// one output byte per cycle while out_stall is low; a transaction yields 1 to 8 bytes
// and holds the input stage until its last byte, so plain bytes flow at one per cycle
// the input stage walks its byte index while the output register takes bytes
// a new transaction is taken in the cycle the last byte of the previous moves out
// out_stall holds the output register and, through it, the input stage
// arst_n clears the valid flags and the byte index
// ---------------------------------------------------------------------------
module json_string_escaper_top
	import jse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       empty_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end
);

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             first_s1;
	logic             last_s1;
	logic             empty_s1;
	logic [RUN_W-1:0] idx_q;

	byte_t            esc [MAX_RUN];
	logic [RUN_W:0]   esc_len;
	logic [RUN_W:0]   run_len;
	logic [RUN_W-1:0] body_idx;
	logic             is_final;
	byte_t            sel_byte;
	logic             out_load;
	logic             step;
	logic             in_accept;

	always_comb begin
		for (int i = 0; i < MAX_RUN; i++) begin
			esc[i] = CH_QUOTE;
		end
		esc_len = (RUN_W+1)'(2);
		esc[0]  = CH_BSLASH;
		case (data_s1)
			CH_QUOTE:  esc[1] = CH_QUOTE;
			CH_BSLASH: esc[1] = CH_BSLASH;
			C_BS:      esc[1] = CH_B;
			C_FF:      esc[1] = CH_F;
			C_LF:      esc[1] = CH_N;
			C_CR:      esc[1] = CH_R;
			C_TAB:     esc[1] = CH_T;
			default: begin
				if (data_s1 < CTRL_LIMIT) begin
					esc[1]  = CH_U;
					esc[2]  = CH_ZERO;
					esc[3]  = CH_ZERO;
					esc[4]  = hex_char(data_s1[7:4]);
					esc[5]  = hex_char(data_s1[3:0]);
					esc_len = (RUN_W+1)'(6);
				end else begin
					esc[0]  = data_s1;
					esc_len = (RUN_W+1)'(1);
				end
			end
		endcase
	end

	always_comb begin
		if (empty_s1) begin
			run_len = (RUN_W+1)'(2);
		end else begin
			run_len = esc_len + (RUN_W+1)'(first_s1) + (RUN_W+1)'(last_s1);
		end
		is_final = ({1'b0, idx_q} == (run_len - (RUN_W+1)'(1)));
		body_idx = idx_q - RUN_W'(first_s1);
		if (empty_s1) begin
			sel_byte = CH_QUOTE;
		end else if (first_s1 && idx_q == '0) begin
			sel_byte = CH_QUOTE;
		end else if ({1'b0, body_idx} < esc_len) begin
			sel_byte = esc[body_idx];
		end else begin
			sel_byte = CH_QUOTE;
		end
	end

	assign out_load  = !out_valid || !out_stall;
	assign step      = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !(out_load && is_final);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (step && is_final) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				idx_q <= is_final ? '0 : idx_q + RUN_W'(1);
			end
			if (out_load) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
			empty_s1 <= empty_string;
		end
		if (step) begin
			out_byte <= sel_byte;
			run_end  <= is_final;
		end
	end

endmodule

// ===== rtl/jse_checker.sv =====
// ---------------------------------------------------------------------------
// jse_checker
// port level checks of the json string escaper, bound to the top level
// ---------------------------------------------------------------------------
`include "json_string_escaper_top_defines.svh"

module jse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_end
);

	// a stalled output transaction holds
	`JSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_end), "output changed while stalled")

	// bytes of one run follow without a gap
	`JSE_ASSERT_NEXT(a_run_cont, out_valid && !run_end, out_valid, "gap inside an escape run")

	// input stall with an empty output register means a byte is on its way
	`JSE_ASSERT_NEXT(a_stall_fill, !out_valid && in_stall, out_valid, "input stalled with idle output")

	// an accepted transaction moves through the input stage into the output register
	`JSE_ASSERT_NEXT(a_in_reach, $past(in_valid && !in_stall), out_valid, "accepted transaction did not reach the output")

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.run_end   (run_end)
);
